FILE: src/arc_pkg.sv
// Shared types, codes and reset constants for the ARP resolve cache.
// No dependencies; every other file of the block uses it by scoped names.
`timescale 1ns / 1ps

package arc_pkg;

    // default table depths handed to the top level
    localparam int MAP_ENTRIES_DEF  = 16;
    localparam int PEND_ENTRIES_DEF = 8;

    // index width of the shared scan unit, wide enough for the deepest table
    localparam int SCAN_IDX_W = 8;

    // configuration reset values
    localparam logic [15:0] RETRY_RESET = 16'd5000;
    localparam logic [31:0] LIFE_RESET  = 32'd30000;

    localparam logic [47:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;

    // input actions
    localparam logic [1:0] ACT_SEND = 2'd0;
    localparam logic [1:0] ACT_RECV = 2'd1;
    localparam logic [1:0] ACT_TICK = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_IPV4    = 2'd0;
    localparam logic [1:0] KIND_REQ     = 2'd1;
    localparam logic [1:0] KIND_REPLY   = 2'd2;
    localparam logic [1:0] KIND_DELIVER = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_OWN_MAC  = 2'd0;
    localparam logic [1:0] CFG_OWN_IP   = 2'd1;
    localparam logic [1:0] CFG_RETRY    = 2'd2;
    localparam logic [1:0] CFG_LIFETIME = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] next_hop_ip;
        logic [15:0] buffer_tag;
        logic [47:0] frame_dst_mac;
        logic        frame_is_ipv4;
        logic        parse_ok;
        logic        arp_is_request;
        logic [47:0] arp_sender_mac;
        logic [31:0] arp_sender_ip;
        logic [31:0] arp_target_ip;
        logic [15:0] elapsed_ms;
    } t_item;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [47:0] dst_mac;
        logic [15:0] out_tag;
        logic [47:0] target_mac;
        logic [31:0] target_ip;
    } t_result;

    // one table entry as the scan unit sees it
    typedef struct packed {
        logic                  valid;
        logic [31:0]           key;
        logic [63:0]           tstamp;
        logic [SCAN_IDX_W-1:0] idx;
    } t_scan_elem;

    // what one pass of the scan unit has found
    typedef struct packed {
        logic                  hit;
        logic [SCAN_IDX_W-1:0] hit_idx;
        logic                  hit_late;
        logic                  free;
        logic [SCAN_IDX_W-1:0] free_idx;
        logic                  min_seen;
        logic [SCAN_IDX_W-1:0] min_idx;
        logic [63:0]           min_tstamp;
    } t_scan_res;

endpackage

FILE: src/arp_resolve_cache_unit.sv
// ARP resolve cache top level: sequencer, address map and pending tables.
// Depends on arc_pkg and arc_scan_unit.
`timescale 1ns / 1ps

// Usage: present a word on i_item with start high while busy is low; it is
// taken at that edge and busy rises until the word is done; a receive that
// is filtered out or carries IPv4 is done at that edge and busy stays low.
// Action send looks up the map, then on a miss the pending table; receive
// filters the destination, delivers IPv4, learns the ARP sender and may
// answer or release a held datagram; tick advances the millisecond clock and
// sweeps out expired map entries. At most one result per word shows on
// o_result with o_result_valid high for exactly one cycle; the receiver
// cannot stall it. No result comes from a tick, a dropped send or an ARP
// with nothing held.
// Each table is walked one entry a cycle through the shared scan unit and
// registered memory reads; a new word is taken at the earliest at the end of
// the first cycle with busy low. Configuration writes on i_cfg_we take
// effect at once; the user is to make them only while idle; the block does
// not check it. Synchronous reset clears the clock, both valid vectors and
// the sequencer; table contents need no clearing.

module arp_resolve_cache_unit #(
    parameter int MAP_ENTRIES     = arc_pkg::MAP_ENTRIES_DEF,
    parameter int PENDING_ENTRIES = arc_pkg::PEND_ENTRIES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  arc_pkg::t_item   i_item,
    output logic             o_result_valid,
    output arc_pkg::t_result o_result,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [47:0]      i_cfg_wdata
);

    localparam int MA    = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
    localparam int PA    = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
    localparam int IW    = (MA > PA) ? MA : PA;
    localparam int MAXN  = (MAP_ENTRIES > PENDING_ENTRIES) ? MAP_ENTRIES : PENDING_ENTRIES;
    localparam int CW    = $clog2(MAXN + 1);
    localparam int SW    = arc_pkg::SCAN_IDX_W;

    typedef enum logic [3:0] {
        S_IDLE, S_MSCAN, S_MREAD, S_PSCAN, S_LSCAN,
        S_RPSCAN, S_RPREAD, S_OUT, S_TSCAN
    } t_state;

    t_state               r_state, n_state;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic                 r_rd_vld, n_rd_vld;
    logic [IW-1:0]        r_rd_idx, n_rd_idx;
    logic [IW-1:0]        r_sel, n_sel;
    arc_pkg::t_item       r_item, n_item;
    logic [63:0]          r_now, n_now;
    logic [47:0]          r_own_mac, n_own_mac;
    logic [31:0]          r_own_ip, n_own_ip;
    logic [15:0]          r_retry, n_retry;
    logic [31:0]          r_life, n_life;
    logic [MAP_ENTRIES-1:0]     r_map_valid, n_map_valid;
    logic [PENDING_ENTRIES-1:0] r_pend_valid, n_pend_valid;
    arc_pkg::t_result     r_res, n_res;
    logic                 r_res_vld, n_res_vld;

    // table memories and their registered read data
    logic [31:0] mem_map_ip  [MAP_ENTRIES];
    logic [47:0] mem_map_mac [MAP_ENTRIES];
    logic [63:0] mem_map_exp [MAP_ENTRIES];
    logic [31:0] mem_pend_ip [PENDING_ENTRIES];
    logic [15:0] mem_pend_tag[PENDING_ENTRIES];
    logic [63:0] mem_pend_dl [PENDING_ENTRIES];
    logic [31:0] r_mip_q;
    logic [47:0] r_mmac_q;
    logic [63:0] r_mexp_q;
    logic [31:0] r_pip_q;
    logic [15:0] r_ptag_q;
    logic [63:0] r_pdl_q;

    logic [MA-1:0] map_raddr, map_waddr;
    logic [PA-1:0] pend_raddr, pend_waddr;
    logic          map_we, pend_we;

    logic               accept, dst_ok, scan_map, scan_pend, scanning;
    logic               issue, scan_done, sc_clear, sc_step, sc_le;
    logic [CW-1:0]      limit;
    logic [MA-1:0]      rd_midx;
    logic [PA-1:0]      rd_pidx;
    logic [MA-1:0]      mslot;
    logic [PA-1:0]      pslot;
    arc_pkg::t_scan_elem sc_elem;
    arc_pkg::t_scan_res  sc_res;

    assign busy           = (r_state != S_IDLE);
    assign accept         = start && !busy;
    assign o_result_valid = r_res_vld;
    assign o_result       = r_res;

    assign dst_ok = (i_item.frame_dst_mac == arc_pkg::BCAST_MAC) ||
                    (i_item.frame_dst_mac == r_own_mac);

    // scan control: issue one address a cycle; the registered read data returns in the next cycle
    assign scan_map  = (r_state == S_MSCAN) || (r_state == S_LSCAN) || (r_state == S_TSCAN);
    assign scan_pend = (r_state == S_PSCAN) || (r_state == S_RPSCAN);
    assign scanning  = scan_map || scan_pend;
    assign limit     = scan_map ? CW'(MAP_ENTRIES) : CW'(PENDING_ENTRIES);
    assign issue     = scanning && (r_cnt < limit);
    assign scan_done = (r_cnt == limit) && !r_rd_vld;
    assign sc_clear  = scanning && (r_cnt == '0) && !r_rd_vld;
    assign sc_step   = scanning && r_rd_vld;
    assign rd_midx   = r_rd_idx[MA-1:0];
    assign rd_pidx   = r_rd_idx[PA-1:0];

    assign map_raddr  = (r_state == S_MREAD) ? r_sel[MA-1:0] : r_cnt[MA-1:0];
    assign pend_raddr = (r_state == S_RPREAD) ? r_sel[PA-1:0] : r_cnt[PA-1:0];

    // present the entry read last cycle to the scan unit
    always_comb begin
        if (scan_map) begin
            sc_elem.valid  = r_map_valid[rd_midx];
            sc_elem.key    = r_mip_q;
            sc_elem.tstamp = r_mexp_q;
        end else begin
            sc_elem.valid  = r_pend_valid[rd_pidx];
            sc_elem.key    = r_pip_q;
            sc_elem.tstamp = r_pdl_q;
        end
        sc_elem.idx = SW'(r_rd_idx);
    end

    arc_scan_unit u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (sc_clear),
        .i_step     (sc_step),
        .i_elem     (sc_elem),
        .i_key      ((r_item.action == arc_pkg::ACT_SEND) ? r_item.next_hop_ip
                                                          : r_item.arp_sender_ip),
        .i_ref_time (r_now),
        .o_res      (sc_res),
        .o_cur_le   (sc_le)
    );

    // choose slots from the scan results
    always_comb begin
        if (sc_res.hit) begin
            mslot = sc_res.hit_idx[MA-1:0];
        end else if (sc_res.free) begin
            mslot = sc_res.free_idx[MA-1:0];
        end else begin
            mslot = sc_res.min_idx[MA-1:0];
        end
        pslot = sc_res.hit ? sc_res.hit_idx[PA-1:0] : sc_res.free_idx[PA-1:0];
    end

    // sequencer next state
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_rd_vld     = 1'b0;
        n_rd_idx     = r_rd_idx;
        n_sel        = r_sel;
        n_item       = r_item;
        n_now        = r_now;
        n_own_mac    = r_own_mac;
        n_own_ip     = r_own_ip;
        n_retry      = r_retry;
        n_life       = r_life;
        n_map_valid  = r_map_valid;
        n_pend_valid = r_pend_valid;
        n_res        = r_res;
        n_res_vld    = 1'b0;
        map_we       = 1'b0;
        map_waddr    = mslot;
        pend_we      = 1'b0;
        pend_waddr   = pslot;

        // take configuration writes
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                arc_pkg::CFG_OWN_MAC:  n_own_mac = i_cfg_wdata;
                arc_pkg::CFG_OWN_IP:   n_own_ip  = i_cfg_wdata[31:0];
                arc_pkg::CFG_RETRY:    n_retry   = i_cfg_wdata[15:0];
                arc_pkg::CFG_LIFETIME: n_life    = i_cfg_wdata[31:0];
            endcase
        end

        // advance the scan address
        if (issue) begin
            n_cnt    = r_cnt + CW'(1);
            n_rd_vld = 1'b1;
            n_rd_idx = r_cnt[IW-1:0];
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_item = i_item;
                    n_cnt  = '0;
                    case (i_item.action)
                        arc_pkg::ACT_SEND: n_state = S_MSCAN;
                        arc_pkg::ACT_RECV: begin
                            if (dst_ok && i_item.parse_ok) begin
                                if (i_item.frame_is_ipv4) begin
                                    n_res_vld = 1'b1;
                                    n_res     = '0;
                                    n_res.out_kind = arc_pkg::KIND_DELIVER;
                                    n_res.out_tag  = i_item.buffer_tag;
                                end else begin
                                    n_state = S_LSCAN;
                                end
                            end
                        end
                        arc_pkg::ACT_TICK: begin
                            n_now   = r_now + 64'(i_item.elapsed_ms);
                            n_state = S_TSCAN;
                        end
                        default: ;
                    endcase
                end
            end
            S_MSCAN: begin
                if (scan_done) begin
                    if (sc_res.hit) begin
                        n_sel   = sc_res.hit_idx[IW-1:0];
                        n_state = S_MREAD;
                    end else begin
                        n_cnt   = '0;
                        n_state = S_PSCAN;
                    end
                end
            end
            S_MREAD: n_state = S_OUT;
            S_PSCAN: begin
                if (scan_done) begin
                    n_state = S_IDLE;
                    // store and broadcast unless still inside the retry delay or the table is full
                    if ((sc_res.hit && sc_res.hit_late) || (!sc_res.hit && sc_res.free)) begin
                        pend_we               = 1'b1;
                        n_pend_valid[pslot]   = 1'b1;
                        n_res_vld             = 1'b1;
                        n_res                 = '0;
                        n_res.out_kind        = arc_pkg::KIND_REQ;
                        n_res.dst_mac         = arc_pkg::BCAST_MAC;
                        n_res.target_ip       = r_item.next_hop_ip;
                    end
                end
            end
            S_LSCAN: begin
                if (scan_done) begin
                    map_we              = 1'b1;
                    n_map_valid[mslot]  = 1'b1;
                    if (r_item.arp_is_request && (r_item.arp_target_ip == r_own_ip)) begin
                        n_res_vld        = 1'b1;
                        n_res            = '0;
                        n_res.out_kind   = arc_pkg::KIND_REPLY;
                        n_res.dst_mac    = r_item.arp_sender_mac;
                        n_res.target_mac = r_item.arp_sender_mac;
                        n_res.target_ip  = r_item.arp_sender_ip;
                        n_state          = S_IDLE;
                    end else begin
                        n_cnt   = '0;
                        n_state = S_RPSCAN;
                    end
                end
            end
            S_RPSCAN: begin
                if (scan_done) begin
                    if (sc_res.hit) begin
                        n_sel                                  = sc_res.hit_idx[IW-1:0];
                        n_pend_valid[sc_res.hit_idx[PA-1:0]] = 1'b0;
                        n_state                                = S_RPREAD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_RPREAD: n_state = S_OUT;
            S_OUT: begin
                n_res_vld      = 1'b1;
                n_res          = '0;
                n_res.out_kind = arc_pkg::KIND_IPV4;
                if (r_item.action == arc_pkg::ACT_SEND) begin
                    n_res.dst_mac = r_mmac_q;
                    n_res.out_tag = r_item.buffer_tag;
                end else begin
                    n_res.dst_mac = r_item.arp_sender_mac;
                    n_res.out_tag = r_ptag_q;
                end
                n_state = S_IDLE;
            end
            S_TSCAN: begin
                // drop entries whose expiry has been reached
                if (sc_step && sc_elem.valid && sc_le) begin
                    n_map_valid[rd_midx] = 1'b0;
                end
                if (scan_done) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    // hold state, configuration and the registered result
    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_res    <= n_res;
        r_sel    <= n_sel;
        r_rd_idx <= n_rd_idx;
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_rd_vld     <= 1'b0;
            r_now        <= '0;
            r_own_mac    <= '0;
            r_own_ip     <= '0;
            r_retry      <= arc_pkg::RETRY_RESET;
            r_life       <= arc_pkg::LIFE_RESET;
            r_map_valid  <= '0;
            r_pend_valid <= '0;
            r_res_vld    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_rd_vld     <= n_rd_vld;
            r_now        <= n_now;
            r_own_mac    <= n_own_mac;
            r_own_ip     <= n_own_ip;
            r_retry      <= n_retry;
            r_life       <= n_life;
            r_map_valid  <= n_map_valid;
            r_pend_valid <= n_pend_valid;
            r_res_vld    <= n_res_vld;
        end
    end

    // map memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (map_we) begin
            mem_map_ip[map_waddr]  <= r_item.arp_sender_ip;
            mem_map_mac[map_waddr] <= r_item.arp_sender_mac;
            mem_map_exp[map_waddr] <= r_now + 64'(r_life);
        end
        r_mip_q  <= mem_map_ip[map_raddr];
        r_mmac_q <= mem_map_mac[map_raddr];
        r_mexp_q <= mem_map_exp[map_raddr];
    end

    // pending memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (pend_we) begin
            mem_pend_ip[pend_waddr]  <= r_item.next_hop_ip;
            mem_pend_tag[pend_waddr] <= r_item.buffer_tag;
            mem_pend_dl[pend_waddr]  <= r_now + 64'(r_retry);
        end
        r_pip_q  <= mem_pend_ip[pend_raddr];
        r_ptag_q <= mem_pend_tag[pend_raddr];
        r_pdl_q  <= mem_pend_dl[pend_raddr];
    end

endmodule

FILE: src/arc_scan_unit.sv
// Shared compare unit: takes one entry a cycle on i_step, tracking the first
// key match, the first free entry and the earliest time stamp. Uses arc_pkg.
`timescale 1ns / 1ps

module arc_scan_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_clear,
    input  logic               i_step,
    input  arc_pkg::t_scan_elem i_elem,
    input  logic [31:0]        i_key,
    input  logic [63:0]        i_ref_time,
    output arc_pkg::t_scan_res o_res,
    output logic               o_cur_le
);

    arc_pkg::t_scan_res r_res;
    arc_pkg::t_scan_res n_res;
    logic               cur_lt;

    // compare the current entry against the reference time
    assign cur_lt   = i_elem.tstamp < i_ref_time;
    assign o_cur_le = cur_lt || (i_elem.tstamp == i_ref_time);
    assign o_res    = r_res;

    // fold the current entry into the running results
    always_comb begin
        n_res = r_res;
        if (i_clear) begin
            n_res.hit      = 1'b0;
            n_res.free     = 1'b0;
            n_res.min_seen = 1'b0;
        end else if (i_step) begin
            if (!r_res.hit && i_elem.valid && (i_elem.key == i_key)) begin
                n_res.hit      = 1'b1;
                n_res.hit_idx  = i_elem.idx;
                n_res.hit_late = cur_lt;
            end
            if (!r_res.free && !i_elem.valid) begin
                n_res.free     = 1'b1;
                n_res.free_idx = i_elem.idx;
            end
            if (!r_res.min_seen || (i_elem.tstamp < r_res.min_tstamp)) begin
                n_res.min_seen   = 1'b1;
                n_res.min_idx    = i_elem.idx;
                n_res.min_tstamp = i_elem.tstamp;
            end
        end
    end

    // hold the results; only the found flags need reset
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (!i_rst_n) begin
            r_res.hit      <= 1'b0;
            r_res.free     <= 1'b0;
            r_res.min_seen <= 1'b0;
        end
    end

endmodule

FILE: src/arc_checker.sv
// Port-level checks for the ARP resolve cache, bound to the top level.
// Depends on arc_pkg and arp_resolve_cache_unit.
`timescale 1ns / 1ps

module arc_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input arc_pkg::t_item   i_item,
    input logic             o_result_valid,
    input arc_pkg::t_result o_result
);

    // a result only follows a taken word or work in progress
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy || start))
        else $error("result without a word in progress");

    // a request goes to broadcast with no tag and no target MAC
    a_req_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_result.out_kind == arc_pkg::KIND_REQ)) |->
        ((o_result.dst_mac == arc_pkg::BCAST_MAC) && (o_result.out_tag == 16'd0) &&
         (o_result.target_mac == 48'd0)))
        else $error("malformed ARP request word");

    // a delivered datagram carries only its tag
    a_deliver_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_result.out_kind == arc_pkg::KIND_DELIVER)) |->
        ((o_result.dst_mac == 48'd0) && (o_result.target_mac == 48'd0) &&
         (o_result.target_ip == 32'd0)))
        else $error("malformed deliver word");

    // a tick always sweeps the map
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.action == arc_pkg::ACT_TICK)) |=> busy)
        else $error("tick did not start a sweep");

    // reset leaves the block idle and silent
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!busy && !o_result_valid))
        else $error("not idle after reset");

endmodule

bind arp_resolve_cache_unit arc_checker u_arc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_item         (i_item),
    .o_result_valid (o_result_valid),
    .o_result       (o_result)
);
